// ===== hw/rtl/assert_macros.svh =====
// assertion macros included by the rtl datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// condition must hold at every clock out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, cond, msg)
`define ASSERT_IMPLY(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/rtr_pkg.sv =====
// types, constants and controller/datapath handshake structs for region decode
package rtr_pkg;

    localparam int WORD_W      = 16;
    localparam int MAX_RESULTS = 32;
    localparam int PAIR_W      = $clog2(MAX_RESULTS + 1);
    localparam int EMIT_W      = $clog2(MAX_RESULTS);

    typedef logic signed [WORD_W-1:0] word_t;

    localparam word_t TERM_WORD = 16'sd32767;

    typedef struct packed {
        logic ld_word;     // latch incoming word
        logic first_clr;   // first-line top: set previous top, clear list
        logic first_wr;    // first-line point: append to active list
        logic region_end;  // region terminator
        logic emit_start;
        logic emit_rd;     // read one point pair
        logic emit_ld;     // load output register with one rectangle
        logic top_done;
        logic mrg_rd;      // read active entry at read index
        logic push_word;   // append latched word to merged list
        logic push_rd;     // append read entry to merged list
        logic ri_inc;
        logic merge_done;  // swap banks, merged list becomes active
    } dp_cmd_t;

    typedef struct packed {
        logic word_term;
        logic no_pairs;
        logic last_pair;
        logic ri_lt_ac;
        logic rd_lt_word;
        logic rd_eq_word;
        logic out_free;
    } dp_sts_t;

endpackage

// ===== hw/rtl/rtr_word_if.sv =====
// request channel carrying region body words
interface rtr_word_if;
    logic              valid;
    logic              ready;
    rtr_pkg::word_t    region_word;

    modport source (output valid, output region_word, input ready);
    modport sink (input valid, input region_word, output ready);
endinterface

// ===== hw/rtl/rtr_rect_if.sv =====
// request channel carrying decoded rectangles
interface rtr_rect_if;
    logic              valid;
    logic              ready;
    rtr_pkg::word_t    rect_top;
    rtr_pkg::word_t    rect_bottom;
    rtr_pkg::word_t    rect_left;
    rtr_pkg::word_t    rect_right;
    logic              last_of_band;
    logic              overflowed;

    modport source (
        output valid, output rect_top, output rect_bottom, output rect_left,
        output rect_right, output last_of_band, output overflowed, input ready
    );
    modport sink (
        input valid, input rect_top, input rect_bottom, input rect_left,
        input rect_right, input last_of_band, input overflowed, output ready
    );
endinterface

// ===== hw/rtl/rtr_datapath.sv =====
// point list banks, counters, compare logic and output register
`include "assert_macros.svh"

module rtr_datapath #(
    parameter int MAX_POINTS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  rtr_pkg::dp_cmd_t cmd,
    output rtr_pkg::dp_sts_t sts,
    input  rtr_pkg::word_t   in_word,
    input  logic             out_ready,
    output logic             out_valid,
    output rtr_pkg::word_t   out_top,
    output rtr_pkg::word_t   out_bottom,
    output rtr_pkg::word_t   out_left,
    output rtr_pkg::word_t   out_right,
    output logic             out_last,
    output logic             out_ovf
);

    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int HW = (CW > rtr_pkg::PAIR_W) ? CW : rtr_pkg::PAIR_W;

    // two banks: one holds the active list, the other collects the merge
    rtr_pkg::word_t mem0 [MAX_POINTS];
    rtr_pkg::word_t mem1 [MAX_POINTS];

    logic [CW-1:0]                  ac_reg;
    logic [CW-1:0]                  mc_reg;
    logic [CW-1:0]                  ri_reg;
    logic [rtr_pkg::EMIT_W-1:0]     ei_reg;
    logic                           ovf_reg;
    logic                           act_bank_reg;
    logic                           out_valid_reg;
    rtr_pkg::word_t                 prev_top_reg;
    rtr_pkg::word_t                 cur_word_reg;
    rtr_pkg::word_t                 rd0_reg;
    rtr_pkg::word_t                 rd1_reg;
    rtr_pkg::word_t                 top_reg;
    rtr_pkg::word_t                 bottom_reg;
    rtr_pkg::word_t                 left_reg;
    rtr_pkg::word_t                 right_reg;
    logic                           last_reg;
    logic                           ovf_out_reg;

    logic                           ac_room;
    logic                           mc_room;
    logic                           push;
    logic                           rd_en;
    logic [AW-1:0]                  ra0;
    logic [AW-1:0]                  ra1;
    logic                           wr_en;
    logic                           wr_bank;
    logic [AW-1:0]                  wr_addr;
    rtr_pkg::word_t                 wr_data;
    logic [HW-1:0]                  half;
    logic [rtr_pkg::PAIR_W-1:0]     npairs;

    assign ac_room = ac_reg < CW'(MAX_POINTS);
    assign mc_room = mc_reg < CW'(MAX_POINTS);
    assign push    = cmd.push_word | cmd.push_rd;
    assign rd_en   = cmd.emit_rd | cmd.mrg_rd;
    assign ra0     = cmd.emit_rd ? AW'({ei_reg, 1'b0}) : ri_reg[AW-1:0];
    assign ra1     = AW'({ei_reg, 1'b1});

    // pairs emitted per band, capped at the result limit
    assign half   = HW'(ac_reg >> 1);
    assign npairs = (half > HW'(rtr_pkg::MAX_RESULTS)) ?
                    rtr_pkg::PAIR_W'(rtr_pkg::MAX_RESULTS) : rtr_pkg::PAIR_W'(half);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_bank = act_bank_reg;
        wr_addr = ac_reg[AW-1:0];
        wr_data = in_word;
        if (cmd.first_wr)
        begin
            wr_en = ac_room;
        end
        else if (push)
        begin
            wr_en   = mc_room;
            wr_bank = ~act_bank_reg;
            wr_addr = mc_reg[AW-1:0];
            wr_data = cmd.push_rd ? rd0_reg : cur_word_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && !wr_bank)
        begin
            mem0[wr_addr] <= wr_data;
        end
        if (wr_en && wr_bank)
        begin
            mem1[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd0_reg <= act_bank_reg ? mem1[ra0] : mem0[ra0];
            rd1_reg <= act_bank_reg ? mem1[ra1] : mem0[ra1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ac_reg        <= '0;
            mc_reg        <= '0;
            ri_reg        <= '0;
            ei_reg        <= '0;
            ovf_reg       <= 1'b0;
            act_bank_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_top_reg  <= '0;
        end
        else
        begin
            if (cmd.first_clr)
            begin
                prev_top_reg <= in_word;
                ac_reg       <= '0;
            end
            if (cmd.first_wr)
            begin
                if (ac_room)
                begin
                    ac_reg <= ac_reg + CW'(1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.region_end)
            begin
                ac_reg <= '0;
                mc_reg <= '0;
                ri_reg <= '0;
            end
            if (cmd.emit_start)
            begin
                ei_reg <= '0;
            end
            if (cmd.emit_ld)
            begin
                ei_reg <= ei_reg + rtr_pkg::EMIT_W'(1);
            end
            if (cmd.top_done)
            begin
                prev_top_reg <= cur_word_reg;
                mc_reg       <= '0;
                ri_reg       <= '0;
            end
            if (push)
            begin
                if (mc_room)
                begin
                    mc_reg <= mc_reg + CW'(1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.ri_inc)
            begin
                ri_reg <= ri_reg + CW'(1);
            end
            if (cmd.merge_done)
            begin
                act_bank_reg <= ~act_bank_reg;
                ac_reg       <= mc_reg;
                mc_reg       <= '0;
                ri_reg       <= '0;
            end
            if (cmd.emit_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_word)
        begin
            cur_word_reg <= in_word;
        end
        if (cmd.emit_ld)
        begin
            top_reg     <= prev_top_reg;
            bottom_reg  <= cur_word_reg;
            left_reg    <= rd0_reg;
            right_reg   <= rd1_reg;
            last_reg    <= sts.last_pair;
            ovf_out_reg <= ovf_reg;
        end
    end

    assign sts.word_term  = in_word == rtr_pkg::TERM_WORD;
    assign sts.no_pairs   = npairs == '0;
    assign sts.last_pair  = (rtr_pkg::PAIR_W'(ei_reg) + rtr_pkg::PAIR_W'(1)) == npairs;
    assign sts.ri_lt_ac   = ri_reg < ac_reg;
    assign sts.rd_lt_word = rd0_reg < cur_word_reg;
    assign sts.rd_eq_word = rd0_reg == cur_word_reg;
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_top    = top_reg;
    assign out_bottom = bottom_reg;
    assign out_left   = left_reg;
    assign out_right  = right_reg;
    assign out_last   = last_reg;
    assign out_ovf    = ovf_out_reg;

    `ASSERT_ALWAYS(a_ac_bound, ac_reg <= CW'(MAX_POINTS), "active count past capacity")
    `ASSERT_ALWAYS(a_ri_bound, ri_reg <= ac_reg, "read index past active count")
    `ASSERT_NEXT(a_ovf_sticky, ovf_reg, ovf_reg, "overflow flag cleared")
    `ASSERT_IMPLY(a_emit_free, cmd.emit_ld, !out_valid_reg || out_ready, "rectangle overwritten")

endmodule

// ===== hw/rtl/rtr_controller.sv =====
// sequencer for scanline parsing, rectangle emission and list merge
module rtr_controller (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  rtr_pkg::dp_sts_t sts,
    output rtr_pkg::dp_cmd_t cmd
);

    typedef enum logic [9:0] {
        S_TOP_FIRST = 10'b00_0000_0001,
        S_PTS_FIRST = 10'b00_0000_0010,
        S_TOP       = 10'b00_0000_0100,
        S_MERGE     = 10'b00_0000_1000,
        S_EMIT_RD   = 10'b00_0001_0000,
        S_EMIT_WR   = 10'b00_0010_0000,
        S_MRG_RD    = 10'b00_0100_0000,
        S_MRG_CMP   = 10'b00_1000_0000,
        S_FLUSH_RD  = 10'b01_0000_0000,
        S_FLUSH_WR  = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = state_reg inside {S_TOP_FIRST, S_PTS_FIRST, S_TOP, S_MERGE};

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_TOP_FIRST:
            begin
                // terminator here is an empty region
                if (in_valid && !sts.word_term)
                begin
                    cmd.first_clr = 1'b1;
                    state_next    = S_PTS_FIRST;
                end
            end
            S_PTS_FIRST:
            begin
                if (in_valid)
                begin
                    if (sts.word_term)
                    begin
                        state_next = S_TOP;
                    end
                    else
                    begin
                        cmd.first_wr = 1'b1;
                    end
                end
            end
            S_TOP:
            begin
                if (in_valid)
                begin
                    if (sts.word_term)
                    begin
                        cmd.region_end = 1'b1;
                        state_next     = S_TOP_FIRST;
                    end
                    else
                    begin
                        cmd.ld_word    = 1'b1;
                        cmd.emit_start = 1'b1;
                        state_next     = S_EMIT_RD;
                    end
                end
            end
            S_EMIT_RD:
            begin
                if (sts.no_pairs)
                begin
                    cmd.top_done = 1'b1;
                    state_next   = S_MERGE;
                end
                else
                begin
                    cmd.emit_rd = 1'b1;
                    state_next  = S_EMIT_WR;
                end
            end
            S_EMIT_WR:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_ld = 1'b1;
                    if (sts.last_pair)
                    begin
                        cmd.top_done = 1'b1;
                        state_next   = S_MERGE;
                    end
                    else
                    begin
                        state_next = S_EMIT_RD;
                    end
                end
            end
            S_MERGE:
            begin
                if (in_valid)
                begin
                    if (sts.word_term)
                    begin
                        state_next = S_FLUSH_RD;
                    end
                    else
                    begin
                        cmd.ld_word = 1'b1;
                        state_next  = S_MRG_RD;
                    end
                end
            end
            S_MRG_RD:
            begin
                if (sts.ri_lt_ac)
                begin
                    cmd.mrg_rd = 1'b1;
                    state_next = S_MRG_CMP;
                end
                else
                begin
                    cmd.push_word = 1'b1;
                    state_next    = S_MERGE;
                end
            end
            S_MRG_CMP:
            begin
                if (sts.rd_lt_word)
                begin
                    cmd.push_rd = 1'b1;
                    cmd.ri_inc  = 1'b1;
                    state_next  = S_MRG_RD;
                end
                else if (sts.rd_eq_word)
                begin
                    // equal points cancel
                    cmd.ri_inc = 1'b1;
                    state_next = S_MERGE;
                end
                else
                begin
                    cmd.push_word = 1'b1;
                    state_next    = S_MERGE;
                end
            end
            S_FLUSH_RD:
            begin
                if (sts.ri_lt_ac)
                begin
                    cmd.mrg_rd = 1'b1;
                    state_next = S_FLUSH_WR;
                end
                else
                begin
                    cmd.merge_done = 1'b1;
                    state_next     = S_TOP;
                end
            end
            S_FLUSH_WR:
            begin
                cmd.push_rd = 1'b1;
                cmd.ri_inc  = 1'b1;
                state_next  = S_FLUSH_RD;
            end
            default:
            begin
                state_next = S_TOP_FIRST;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_TOP_FIRST;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/region_to_rectangles.sv =====
// Region body decoder: turns scanline inversion points into rectangles.
// Input channel "region" takes one signed 16-bit word per request: for each
// scanline a top word, its sorted inversion points and a 32767 terminator;
// a 32767 in the top position ends the region.
// Output channel "rects" gives one rectangle per request, with last_of_band
// on the final rectangle of a band and the sticky overflowed flag.
// Controller states, named without the S_ prefix, that each word passes through:
//   first-line top or point: TOP_FIRST or PTS_FIRST
//   later top: TOP, EMIT_RD+EMIT_WR per pair (up to 32) or EMIT_RD, plus stalls
//   merge point: MERGE+MRG_RD, MRG_CMP+MRG_RD per lower entry, MRG_CMP if compared
//   merge terminator: MERGE+FLUSH_RD, FLUSH_WR+FLUSH_RD per leftover active entry
// A rectangle is held in an output register; while the receiver stalls the
// band emission waits on that register and no new word is taken.
// Reset clears the counters, the overflow flag and the parse state; the
// block is ready for a first-line top word in the cycle after reset.
module region_to_rectangles #(
    parameter int MAX_POINTS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    rtr_word_if.sink   region,
    rtr_rect_if.source rects
);

    rtr_pkg::dp_cmd_t cmd;
    rtr_pkg::dp_sts_t sts;
    logic             in_ready;

    rtr_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (region.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rtr_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_word    (region.region_word),
        .out_ready  (rects.ready),
        .out_valid  (rects.valid),
        .out_top    (rects.rect_top),
        .out_bottom (rects.rect_bottom),
        .out_left   (rects.rect_left),
        .out_right  (rects.rect_right),
        .out_last   (rects.last_of_band),
        .out_ovf    (rects.overflowed)
    );

    assign region.ready = in_ready;

endmodule
